@@ design/upd_pkg.sv @@
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and the hex digit classifier for the URL
// percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  // One queued command: a single result, or a literal '%' followed by the
  // carried byte when the two flag is set.
  typedef struct packed {
    logic [7:0] data;
    logic       string_last;
    logic       bad;
    logic       two;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] ch);
    hex_t       r;
    logic [7:0] d;
    d = 8'd0;
    r.ok = 1'b0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      d = ch - CH_ZERO;
      r.ok = 1'b1;
    end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
      d = ch - CH_UPPER_A + HEX_TEN;
      r.ok = 1'b1;
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
      d = ch - CH_LOWER_A + HEX_TEN;
      r.ok = 1'b1;
    end
    r.value = d[3:0];
    return r;
  endfunction

endpackage

@@ design/upd_if.sv @@
// ----------------------------------------------------------------------------
// upd_in_if / upd_out_if
// Valid/ready channels for raw input words and decoded result words.
// ----------------------------------------------------------------------------
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_last;
  logic       bad_escape;

  modport source (output valid, output out_byte, output run_last,
                  output string_last, output bad_escape, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input string_last, input bad_escape, output ready);
endinterface

@@ design/upd_front.sv @@
// ----------------------------------------------------------------------------
// upd_front
// Accepts input words, tracks the escape state and pushes result commands.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic              clk,
  input  logic              rst,
  upd_in_if.sink            in_ch,
  input  upd_pkg::q_status_t q_stat,
  output logic              push,
  output upd_pkg::cmd_t     push_cmd
);
  import upd_pkg::*;

  localparam logic [1:0] PH_PLAIN   = 2'd0;
  localparam logic [1:0] PH_PERCENT = 2'd1;
  localparam logic [1:0] PH_DIGIT   = 2'd2;
  localparam logic [1:0] PH_SWALLOW = 2'd3;

  logic [1:0] phase, phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       high_bad, high_bad_next;
  logic       accept;
  hex_t       hx;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign hx          = hex_decode(in_ch.in_byte);

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    high_bad_next    = high_bad;
    push             = 1'b0;
    push_cmd.data        = in_ch.in_byte;
    push_cmd.string_last = in_ch.in_last;
    push_cmd.bad         = 1'b0;
    push_cmd.two         = 1'b0;
    if (accept) begin
      case (phase)
        PH_PLAIN: begin
          if (in_ch.in_byte == CH_PERCENT && !in_ch.in_last) begin
            phase_next = PH_PERCENT;
          end else begin
            push = 1'b1;
          end
        end
        PH_PERCENT: begin
          if (in_ch.in_last) begin
            push         = 1'b1;
            push_cmd.two = 1'b1;
            phase_next   = PH_PLAIN;
          end else begin
            high_bad_next    = !hx.ok;
            high_nibble_next = hx.value;
            phase_next       = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          push = 1'b1;
          if (!high_bad && hx.ok) begin
            push_cmd.data = {high_nibble, hx.value};
            phase_next    = PH_PLAIN;
          end else begin
            push_cmd.data        = 8'd0;
            push_cmd.string_last = 1'b1;
            push_cmd.bad         = 1'b1;
            phase_next           = in_ch.in_last ? PH_PLAIN : PH_SWALLOW;
          end
          high_nibble_next = 4'd0;
          high_bad_next    = 1'b0;
        end
        default: begin
          if (in_ch.in_last) begin
            phase_next = PH_PLAIN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PLAIN;
      high_nibble <= 4'd0;
      high_bad    <= 1'b0;
    end else begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      high_bad    <= high_bad_next;
    end
  end

endmodule

@@ design/upd_queue.sv @@
// ----------------------------------------------------------------------------
// upd_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module upd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  upd_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output upd_pkg::q_status_t q_stat,
  output upd_pkg::cmd_t      head
);
  import upd_pkg::*;

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign q_stat.full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_stat.valid = (count != '0);
  assign head         = mem[rd_ptr];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && q_stat.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/upd_back.sv @@
// ----------------------------------------------------------------------------
// upd_back
// Expands queued commands into result words and holds them in the output
// register until the consumer takes them.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic               clk,
  input  logic               rst,
  input  upd_pkg::q_status_t q_stat,
  input  upd_pkg::cmd_t      head,
  output logic               pop,
  upd_out_if.source          out_ch
);
  import upd_pkg::*;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_last;
  logic       bad_escape;
  logic       second;
  logic       load;
  logic       emit_percent;

  // A two-result command stays at the head while its literal '%' goes out.
  assign load         = q_stat.valid && (!out_valid || out_ch.ready);
  assign emit_percent = head.two && !second;
  assign pop          = load && !emit_percent;

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.run_last    = run_last;
  assign out_ch.string_last = string_last;
  assign out_ch.bad_escape  = bad_escape;

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_percent) begin
        out_byte    <= CH_PERCENT;
        run_last    <= 1'b0;
        string_last <= 1'b0;
        bad_escape  <= 1'b0;
      end else begin
        out_byte    <= head.data;
        run_last    <= 1'b1;
        string_last <= head.string_last;
        bad_escape  <= head.bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second    <= emit_percent;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/url_percent_decoder.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent decoder: one encoded byte in per word, decoded bytes
// and an error marker for rejected strings out.
//
//   channel   dir   words carry
//   in_ch     in    in_byte, in_last
//   out_ch    out   out_byte, run_last, string_last, bad_escape
//
// One input word per cycle is accepted while the command queue is not full; a
// word that yields two results (a last byte that follows an opening '%')
// holds the single output register for both results, one after the other.
// An accepted word is written to the command queue, then to the output register.
// rst is synchronous and clears the escape state, the queue and the output.
// A stalled output fills the two-entry command queue, then drops in_ch.ready.
// ----------------------------------------------------------------------------
module url_percent_decoder (
  input  logic      clk,
  input  logic      rst,
  upd_in_if.sink    in_ch,
  upd_out_if.source out_ch
);
  import upd_pkg::*;

  q_status_t q_stat;
  cmd_t      push_cmd;
  cmd_t      head;
  logic      push;
  logic      pop;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  upd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_stat   (q_stat),
    .head     (head)
  );

  upd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ tb/url_percent_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder_tb
// Drives encoded URL strings one byte per word into the decoder and checks
// every result word against a behavioral prediction of the escape decoding.
// Directed strings cover plain bytes, complete and truncated escapes and
// rejected strings. Random strings are then mostly well formed with
// occasional noise. Both sides stall at random, and the receiver also holds
// off for a long stretch at one point.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import upd_pkg::*;

  localparam int unsigned RANDOM_WORDS = 750;
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    DEC_PLAIN,
    DEC_PERCENT,
    DEC_DIGIT,
    DEC_SWALLOW
  } dec_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_last;
    logic       bad;
  } result_t;

  class decode_scoreboard;
    dec_phase_e  phase;
    logic [3:0]  hi_nibble;
    logic        hi_bad;
    result_t     expected_q[$];
    int unsigned errors;

    function new();
      phase     = DEC_PLAIN;
      hi_nibble = 4'd0;
      hi_bad    = 1'b0;
      errors    = 0;
    endfunction

    // Digits carry their value in the low nibble; letters of either case
    // sit at 1..6 in the low nibble and are worth nine more.
    function bit hex_digit(input logic [7:0] ch, output logic [3:0] val);
      logic [7:0] folded;
      folded = ch | 8'h20;
      val = 4'd0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        val = ch[3:0];
        return 1'b1;
      end
      if (folded >= CH_LOWER_A && folded <= CH_LOWER_F) begin
        val = ch[3:0] + 4'd9;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void push(input logic [7:0] d, input logic rl, input logic sl,
                       input logic bad);
      result_t r;
      r.data        = d;
      r.run_last    = rl;
      r.string_last = sl;
      r.bad         = bad;
      expected_q = {expected_q, r};
    endfunction

    function void note_input(input logic [7:0] b, input logic last);
      logic [3:0] v;
      bit         ok;
      case (phase)
        DEC_PLAIN: begin
          if (b == CH_PERCENT && !last) phase = DEC_PERCENT;
          else push(b, 1'b1, last, 1'b0);
        end
        DEC_PERCENT: begin
          if (last) begin
            push(CH_PERCENT, 1'b0, 1'b0, 1'b0);
            push(b, 1'b1, 1'b1, 1'b0);
            phase = DEC_PLAIN;
          end else begin
            ok        = hex_digit(b, v);
            hi_bad    = !ok;
            hi_nibble = v;
            phase     = DEC_DIGIT;
          end
        end
        DEC_DIGIT: begin
          ok = hex_digit(b, v);
          if (!hi_bad && ok) begin
            push({hi_nibble, v}, 1'b1, last, 1'b0);
            phase = DEC_PLAIN;
          end else begin
            push(8'd0, 1'b1, 1'b1, 1'b1);
            phase = last ? DEC_PLAIN : DEC_SWALLOW;
          end
          hi_nibble = 4'd0;
          hi_bad    = 1'b0;
        end
        default: begin
          if (last) phase = DEC_PLAIN;
        end
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void check_result(input logic [7:0] d, input logic rl, input logic sl,
                               input logic bad);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected word: out_byte=%h run_last=%b string_last=%b bad_escape=%b",
               d, rl, sl, bad);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (d !== exp_r.data) begin
        $error("out_byte: expected %h, got %h", exp_r.data, d);
        errors++;
      end
      if (rl !== exp_r.run_last) begin
        $error("run_last: expected %b, got %b", exp_r.run_last, rl);
        errors++;
      end
      if (sl !== exp_r.string_last) begin
        $error("string_last: expected %b, got %b", exp_r.string_last, sl);
        errors++;
      end
      if (bad !== exp_r.bad) begin
        $error("bad_escape: expected %b, got %b", exp_r.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  upd_in_if  in_ch();
  upd_out_if out_ch();

  url_percent_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  decode_scoreboard sb = new();

  int unsigned words_sent = 0;
  int unsigned cycles     = 0;
  bit          quiet      = 1'b0;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;
  logic [7:0]  text_q[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[url_percent_decoder] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!quiet && $urandom_range(99) < 32) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.out_byte, out_ch.run_last, out_ch.string_last,
                      out_ch.bad_escape);
  end

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_word(input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(b, last);
    words_sent++;
    quiet = (words_sent >= 350 && words_sent < 470);
    if (words_sent == 300) hold_req = 1'b1;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_word(s[i], i == s.len() - 1);
  endtask

  task automatic send_queue();
    for (int i = 0; i < text_q.size(); i++)
      send_word(text_q[i], i == text_q.size() - 1);
  endtask

  function automatic logic [7:0] hex_char();
    case ($urandom_range(2))
      0:       return CH_ZERO + 8'($urandom_range(9));
      1:       return CH_UPPER_A + 8'($urandom_range(5));
      default: return CH_LOWER_A + 8'($urandom_range(5));
    endcase
  endfunction

  // Bytes just outside the hex ranges, or anything at all.
  function automatic logic [7:0] near_char();
    case ($urandom_range(6))
      0:       return CH_ZERO - 8'd1;
      1:       return CH_NINE + 8'd1;
      2:       return CH_UPPER_A - 8'd1;
      3:       return CH_UPPER_F + 8'd1;
      4:       return CH_LOWER_A - 8'd1;
      5:       return CH_LOWER_F + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_PERCENT);
    return c;
  endfunction

  function automatic void add_char(input logic [7:0] c);
    text_q = {text_q, c};
  endfunction

  task automatic make_string();
    int unsigned len;
    int unsigned r;
    len = $urandom_range(1, 10);
    text_q.delete();
    if ($urandom_range(99) < 70) begin
      while (text_q.size() < len) begin
        if ($urandom_range(2) == 0) begin
          add_char(CH_PERCENT);
          add_char(hex_char());
          add_char(hex_char());
        end else begin
          add_char(plain_char());
        end
      end
      // Sometimes end on a truncated escape.
      r = $urandom_range(9);
      if (r == 0) begin
        add_char(CH_PERCENT);
      end else if (r == 1) begin
        add_char(CH_PERCENT);
        add_char(hex_char());
      end
    end else begin
      repeat (len) begin
        r = $urandom_range(99);
        if (r < 30)      add_char(CH_PERCENT);
        else if (r < 60) add_char(hex_char());
        else if (r < 80) add_char(near_char());
        else             add_char(8'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned base;
    bit          paused;
    paused = 1'b0;
    rst = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'd0;
    in_ch.in_last = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extreme plain bytes, then escapes complete, truncated and rejected.
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    send_text("%");
    send_text("%z");
    send_text("%41");
    send_text("%fF");
    send_text("%00x");
    send_text("%g1yz");
    send_text("%1G");
    send_text("%9a");

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      if (!paused && words_sent >= 550) begin
        // Let the decoder run dry before offering more words.
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
      end
      make_string();
      send_queue();
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[url_percent_decoder] OK");
    end else begin
      $display("[url_percent_decoder] ERROR");
    end
    $finish;
  end

endmodule
